[rtl/mcg_pkg.sv]
// Shared types and constants for the midpoint circle generator.
package mcg_pkg;

  localparam int CoordW = 16;
  localparam int RadW   = 15;
  localparam int DecW   = 20;
  localparam int ColorW = 16;
  localparam int IdxW   = 3;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [RadW-1:0]   radius;
    logic [ColorW-1:0] color;
  } in_req_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [ColorW-1:0] pixel_color;
    logic              step_last;
    logic              circle_done;
  } out_req_t;

  // Snapshot of one emitting step, handed from the tracker to the emitter.
  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [RadW-1:0]   a;
    logic [RadW-1:0]   b;
    logic [ColorW-1:0] color;
    logic              done;
  } burst_t;

  typedef struct packed {
    logic            busy;
    logic [IdxW-1:0] idx;
  } emit_stat_t;

endpackage

[rtl/mcg_tracker.sv]
// Circle state: centre, offsets and decision variable, loaded by a start request and advanced per step request.
module mcg_tracker import mcg_pkg::*; #(
  parameter int COLOR_BITS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  in_req_t req,
  output logic    emit_go,
  output burst_t  burst
);

  localparam int CW = (COLOR_BITS < ColorW) ? COLOR_BITS : ColorW;

  logic              active_r, active_nxt;
  logic [RadW-1:0]   a_r, a_nxt;
  logic [RadW-1:0]   b_r, b_nxt;
  logic [DecW-1:0]   dec_r, dec_nxt;
  logic [CoordW-1:0] cx_r, cy_r;
  logic [CW-1:0]     color_r;

  logic              is_step;
  logic              meet;
  logic [RadW-1:0]   a_inc;
  logic [RadW-1:0]   b_adv;
  logic [DecW-1:0]   dec_adv;
  logic [DecW-1:0]   a_ext, b_ext;

  always_comb begin
    is_step = (req.command == CMD_STEP);
    meet    = (a_r >= b_r);
    a_ext   = DecW'(a_r);
    b_ext   = DecW'(b_r);
    a_inc   = a_r + RadW'(1);
    if (dec_r[DecW-1]) begin
      dec_adv = dec_r + (a_ext << 2) + DecW'(6);
      b_adv   = b_r;
    end else begin
      dec_adv = dec_r + ((a_ext - b_ext) << 2) + DecW'(10);
      b_adv   = b_r - RadW'(1);
    end

    emit_go    = fire && is_step && active_r;
    active_nxt = active_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    dec_nxt    = dec_r;

    burst.cx    = cx_r;
    burst.cy    = cy_r;
    burst.a     = a_r;
    burst.b     = b_r;
    burst.color = ColorW'(color_r);
    burst.done  = meet || (a_inc > b_adv);

    if (fire && !is_step) begin
      active_nxt = 1'b1;
      a_nxt      = '0;
      b_nxt      = req.radius;
      dec_nxt    = DecW'(3) - (DecW'(req.radius) << 1);
    end else if (emit_go) begin
      if (burst.done) begin
        active_nxt = 1'b0;
      end
      if (!meet) begin
        a_nxt   = a_inc;
        b_nxt   = b_adv;
        dec_nxt = dec_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    dec_r <= dec_nxt;
    if (fire && !is_step) begin
      cx_r    <= req.center_x;
      cy_r    <= req.center_y;
      color_r <= req.color[CW-1:0];
    end
  end

endmodule

[rtl/mcg_emitter.sv]
// Eight-pixel burst sequencer with a registered output stage.
module mcg_emitter import mcg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  burst_t     burst,
  output logic       ready,
  output emit_stat_t stat,
  output logic       out_valid,
  input  logic       out_stall,
  output out_req_t   out_data
);

  logic            busy_r, busy_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  burst_t          snap_r;
  logic            out_valid_r, out_valid_nxt;
  out_req_t        out_r;
  out_req_t        pix;
  logic            out_load;
  logic            issue_last;
  logic [CoordW-1:0] dx, dy;

  // idx[2] swaps the roles of a and b, idx[0] negates x, idx[1] negates y
  always_comb begin
    dx = idx_r[2] ? CoordW'(snap_r.b) : CoordW'(snap_r.a);
    dy = idx_r[2] ? CoordW'(snap_r.a) : CoordW'(snap_r.b);
    pix.pixel_x     = idx_r[0] ? (snap_r.cx - dx) : (snap_r.cx + dx);
    pix.pixel_y     = idx_r[1] ? (snap_r.cy - dy) : (snap_r.cy + dy);
    pix.pixel_color = snap_r.color;
    pix.step_last   = (idx_r == '1);
    pix.circle_done = (idx_r == '1) && snap_r.done;
  end

  always_comb begin
    out_load   = busy_r && (!out_valid_r || !out_stall);
    issue_last = out_load && (idx_r == '1);
    ready      = !busy_r || issue_last;

    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (go) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (out_load) begin
      idx_nxt = idx_r + IdxW'(1);
      if (issue_last) begin
        busy_nxt = 1'b0;
      end
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      snap_r <= burst;
    end
    if (out_load) begin
      out_r <= pix;
    end
  end

  assign stat.busy = busy_r;
  assign stat.idx  = idx_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/midpoint_circle_generator.sv]
// Top level of the command-driven midpoint circle rasterizer.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_data  (in_req_t)
//   out     | output    | out_valid/out_stall | out_data (out_req_t)
//
// A start request emits nothing; it updates state in the cycle it is taken. A
// step request on an active circle emits eight pixels, one per cycle while the
// output is not stalled; the next request is taken on the edge the eighth
// pixel enters the output register.
// Output stalls hold the output register and pause the burst.
// Reset (synchronous, rst_n low) returns the block to idle with nothing queued.
module midpoint_circle_generator import mcg_pkg::*; #(
  parameter int COLOR_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  logic       fire;
  logic       emit_go;
  logic       emit_ready;
  burst_t     burst;
  emit_stat_t emit_stat;

  assign in_stall = !emit_ready;
  assign fire     = in_valid && !in_stall;

  mcg_tracker #(
    .COLOR_BITS(COLOR_BITS)
  ) u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .req    (in_data),
    .emit_go(emit_go),
    .burst  (burst)
  );

  mcg_emitter u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (emit_go),
    .burst    (burst),
    .ready    (emit_ready),
    .stat     (emit_stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.circle_done |-> out_data.step_last)
    else $error("circle_done without step_last");

  a_step_starts_burst: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> emit_stat.busy && (emit_stat.idx == '0))
    else $error("emitting step did not start a burst");

  a_burst_feeds_out: assert property (@(posedge clk) disable iff (!rst_n)
    emit_stat.busy && (emit_stat.idx != '0) |-> out_valid)
    else $error("burst in progress with empty output register");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    emit_stat.busy && (emit_stat.idx != '1) |-> in_stall)
    else $error("request taken in the middle of a burst");

endmodule
